>>> hw/rtl/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg: shared constants and helpers for the compensated double sum
// Binary64 encodings and the magnitude compare used by the summation pipe.
// ----------------------------------------------------------------------------
package cds_pkg;

    typedef logic [63:0] t_fp64;

    localparam t_fp64 C_POS_ZERO    = 64'h0000_0000_0000_0000;
    localparam t_fp64 C_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam int    C_QUIET_BIT   = 51;

    function automatic logic f_is_nan(input t_fp64 v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic f_is_inf(input t_fp64 v);
        return (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
    endfunction

    // |a| >= |b|, false when either side is NaN
    function automatic logic f_mag_ge(input t_fp64 a, input t_fp64 b);
        return !f_is_nan(a) && !f_is_nan(b) && (a[62:0] >= b[62:0]);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/compensated_double_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compensated_double_sum: streaming Neumaier summation of binary64 terms
// Five register stages, one binary64 adder each; total and correction are
// each carried around a single adder stage.
// A last beat's sum passes stages 1 to 4 and is then registered in stage 5.
// Throughput: one beat per cycle; the whole pipe holds only while the
// output register is full and stalled.
// Reset: synchronous, clears total and correction to +0.0 and all valids.
// ----------------------------------------------------------------------------
module compensated_double_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_term_bits,
    input  logic        i_no_term,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_sum_bits
);
    import cds_pkg::*;

    logic  en;
    t_fp64 r_tot, n_tot;
    t_fp64 r_corr, n_corr;
    t_fp64 a_next, d_diff, c_err, c_acc, e_sum;

    logic  r1_v, r1_has, r1_last;
    t_fp64 r1_big, r1_small, r1_next;
    logic  r2_v, r2_has, r2_last;
    t_fp64 r2_small, r2_next, r2_d;
    logic  r3_v, r3_has, r3_last;
    t_fp64 r3_next, r3_e;
    logic  r4_v, r4_last;
    t_fp64 r4_tot, r4_corr;
    logic  r_ov;
    t_fp64 r_sum;

    assign en         = !r_ov || !i_stall;
    assign o_stall    = r_ov && i_stall;
    assign o_valid    = r_ov;
    assign o_sum_bits = r_sum;

    cds_fp64_add u_add_tot  (.i_a(r_tot),    .i_b(i_term_bits), .i_sub(1'b0), .o_sum(a_next));
    cds_fp64_add u_add_diff (.i_a(r1_big),   .i_b(r1_next),     .i_sub(1'b1), .o_sum(d_diff));
    cds_fp64_add u_add_err  (.i_a(r2_d),     .i_b(r2_small),    .i_sub(1'b0), .o_sum(c_err));
    cds_fp64_add u_add_corr (.i_a(r_corr),   .i_b(r3_e),        .i_sub(1'b0), .o_sum(c_acc));
    cds_fp64_add u_add_out  (.i_a(r4_tot),   .i_b(r4_corr),     .i_sub(1'b0), .o_sum(e_sum));

    always_comb begin
        n_tot = r_tot;
        if (i_valid && en) begin
            n_tot = i_is_last ? C_POS_ZERO : (i_no_term ? r_tot : a_next);
        end
        n_corr = r3_has ? c_acc : r_corr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot  <= C_POS_ZERO;
            r_corr <= C_POS_ZERO;
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_tot <= n_tot;
            if (r3_v) begin
                r_corr <= r3_last ? C_POS_ZERO : n_corr;
            end
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_ov <= r4_v && r4_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: total add, order operands by magnitude
            r1_has   <= !i_no_term;
            r1_last  <= i_is_last;
            r1_next  <= i_no_term ? r_tot : a_next;
            r1_big   <= f_mag_ge(r_tot, i_term_bits) ? r_tot : i_term_bits;
            r1_small <= f_mag_ge(r_tot, i_term_bits) ? i_term_bits : r_tot;
            // stage 2: big - next
            r2_has   <= r1_has;
            r2_last  <= r1_last;
            r2_next  <= r1_next;
            r2_small <= r1_small;
            r2_d     <= d_diff;
            // stage 3: + small
            r3_has   <= r2_has;
            r3_last  <= r2_last;
            r3_next  <= r2_next;
            r3_e     <= c_err;
            // stage 4: accumulate correction
            r4_last  <= r3_last;
            r4_tot   <= r3_next;
            r4_corr  <= n_corr;
            // stage 5: emit total + correction
            r_sum    <= e_sum;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/cds_fp64_add.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_fp64_add: binary64 adder, round to nearest even
// Combinational add or subtract of two binary64 values with NaN, infinity,
// zero and subnormal handling.
// ----------------------------------------------------------------------------
module cds_fp64_add (
    input  logic            [63:0] i_a,
    input  logic            [63:0] i_b,
    input  logic                   i_sub,
    output cds_pkg::t_fp64         o_sum
);
    import cds_pkg::*;

    logic        sa, sb;
    logic        a_ge;
    logic        sx, sy;
    logic [10:0] ex_f, ey_f;
    logic [51:0] fx, fy;
    logic [10:0] ex, ey, diff;
    logic [55:0] mx, my, my_sh, st_mask;
    logic        st;
    logic        eff_sub;
    logic [56:0] s;
    logic [5:0]  lz;
    logic        found;
    logic [11:0] sh;
    logic [55:0] t;
    logic [11:0] e;
    logic [10:0] e_field;
    logic        rnd;
    logic [62:0] packed_res;
    t_fp64       b_eff;

    always_comb begin
        sa    = i_a[63];
        sb    = i_b[63] ^ i_sub;
        b_eff = {sb, i_b[62:0]};
        a_ge  = (i_a[62:0] >= i_b[62:0]);
        sx    = a_ge ? sa : sb;
        sy    = a_ge ? sb : sa;
        ex_f  = a_ge ? i_a[62:52] : i_b[62:52];
        ey_f  = a_ge ? i_b[62:52] : i_a[62:52];
        fx    = a_ge ? i_a[51:0] : i_b[51:0];
        fy    = a_ge ? i_b[51:0] : i_a[51:0];
        ex    = (ex_f == 11'd0) ? 11'd1 : ex_f;
        ey    = (ey_f == 11'd0) ? 11'd1 : ey_f;
        mx    = {(ex_f != 11'd0), fx, 3'b000};
        my    = {(ey_f != 11'd0), fy, 3'b000};
        diff  = ex - ey;

        if (diff >= 11'd56) begin
            my_sh   = 56'd0;
            st_mask = '1;
        end else begin
            my_sh   = my >> diff[5:0];
            st_mask = ~({56{1'b1}} << diff[5:0]);
        end
        st = |(my & st_mask);

        eff_sub = sx ^ sy;
        if (eff_sub) begin
            s = {1'b0, mx} - {1'b0, my_sh[55:1], my_sh[0] | st};
        end else begin
            s = {1'b0, mx} + {1'b0, my_sh[55:1], my_sh[0] | st};
        end

        lz    = 6'd56;
        found = 1'b0;
        for (int i = 55; i >= 0; i--) begin
            if (!found && s[i]) begin
                lz    = 6'(55 - i);
                found = 1'b1;
            end
        end

        if (s[56]) begin
            sh = 12'd0;
            t  = {s[56:2], s[1] | s[0]};
            e  = {1'b0, ex} + 12'd1;
        end else begin
            sh = ({6'd0, lz} < ({1'b0, ex} - 12'd1)) ? {6'd0, lz} : ({1'b0, ex} - 12'd1);
            t  = s[55:0] << sh[5:0];
            e  = {1'b0, ex} - sh;
        end

        e_field    = t[55] ? e[10:0] : 11'd0;
        rnd        = t[2] & (t[1] | t[0] | t[3]);
        packed_res = {e_field, t[54:3]} + {62'd0, rnd};

        if (f_is_nan(i_a)) begin
            o_sum = i_a;
            o_sum[C_QUIET_BIT] = 1'b1;
        end else if (f_is_nan(i_b)) begin
            o_sum = i_b;
            o_sum[C_QUIET_BIT] = 1'b1;
        end else if (f_is_inf(i_a) && f_is_inf(i_b) && (sa != sb)) begin
            o_sum = C_DEFAULT_NAN;
        end else if (f_is_inf(i_a)) begin
            o_sum = i_a;
        end else if (f_is_inf(i_b)) begin
            o_sum = b_eff;
        end else if (s == 57'd0) begin
            o_sum = {sx & sy, 63'd0};
        end else if (e >= 12'd2047) begin
            o_sum = {sx, 11'h7FF, 52'd0};
        end else begin
            o_sum = {sx, packed_res};
        end
    end

endmodule
`default_nettype wire
